FILE: design/url_hpe_pkg.sv
// Package for the URL host and port extractor.
// Holds the shared types, codes, widths and character constants.
// No dependencies.
package url_hpe_pkg;

    localparam int HOST_MAX = 256;
    localparam int PORT_MAX = 16;

    localparam int HCAP_W = 9;
    localparam int PCAP_W = 5;
    localparam int BYTE_W = 9;
    localparam int CFG_W  = 9;
    localparam int CHAR_W = 8;

    localparam logic [HCAP_W-1:0] HOST_CAP_RESET = 9'd64;
    localparam logic [PCAP_W-1:0] PORT_CAP_RESET = 5'd6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;

    typedef enum logic [1:0] {
        REG_URL_MODE = 2'd0,
        REG_HOST_CAP = 2'd1,
        REG_PORT_CAP = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_SLASH1 = 3'd0,
        PH_SLASH2 = 3'd1,
        PH_HOST   = 3'd2,
        PH_PORT   = 3'd3,
        PH_ENDED  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HOST = 2'd1,
        KIND_PORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic              url_mode;
        logic [HCAP_W-1:0] hcap;
        logic [PCAP_W-1:0] pcap;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        kind_t             out_kind;
        status_t           status;
        logic [BYTE_W-1:0] consumed;
        logic              port_defaulted;
    } res_t;

endpackage

FILE: design/url_hpe_cfg.sv
// Configuration registers of the URL host and port extractor.
// Presents the mode and the clamped buffer capacities; uses url_hpe_pkg.
module url_hpe_cfg
    import url_hpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    logic              url_mode_reg;
    logic [HCAP_W-1:0] host_cap_reg;
    logic [PCAP_W-1:0] port_cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_mode_reg <= 1'b0;
            host_cap_reg <= HOST_CAP_RESET;
            port_cap_reg <= PORT_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_URL_MODE: url_mode_reg <= cfg_data[0];
                REG_HOST_CAP: host_cap_reg <= cfg_data[HCAP_W-1:0];
                REG_PORT_CAP: port_cap_reg <= cfg_data[PCAP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.url_mode = url_mode_reg;
        cfg.hcap = (host_cap_reg > HCAP_W'(HOST_MAX)) ? HCAP_W'(HOST_MAX) : host_cap_reg;
        cfg.pcap = (port_cap_reg > PCAP_W'(PORT_MAX)) ? PCAP_W'(PORT_MAX) : port_cap_reg;
    end

endmodule

FILE: design/url_hpe_core.sv
// Parse state machine of the URL host and port extractor.
// Holds phase and counters and forms one result per word; uses url_hpe_pkg.
module url_hpe_core
    import url_hpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  logic [CHAR_W-1:0] ch,
    input  logic              start_req,
    output res_t              res
);

    typedef enum logic [2:0] {
        ACT_SLASH,
        ACT_HOST,
        ACT_COLON,
        ACT_PORT,
        ACT_DONE,
        ACT_ERROR,
        ACT_IGNORE
    } act_t;

    phase_t            phase_reg, phase_next;
    logic [HCAP_W-1:0] host_count_reg, host_count_next;
    logic [PCAP_W-1:0] port_count_reg, port_count_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;

    phase_t            eff_phase;
    logic [HCAP_W-1:0] eff_hc, hc_inc;
    logic [PCAP_W-1:0] eff_pc, pc_inc;
    logic [BYTE_W-1:0] eff_bc, bc_inc;
    logic              is_upper, is_lower, is_digit, is_host_ch, is_end;
    act_t              act;

    assign eff_phase = start_req ? PH_SLASH1 : phase_reg;
    assign eff_hc    = start_req ? '0 : host_count_reg;
    assign eff_pc    = start_req ? '0 : port_count_reg;
    assign eff_bc    = start_req ? '0 : byte_count_reg;
    assign hc_inc    = eff_hc + HCAP_W'(1);
    assign pc_inc    = eff_pc + PCAP_W'(1);
    assign bc_inc    = eff_bc + BYTE_W'(1);

    assign is_upper   = (ch >= 8'h41) && (ch <= 8'h5A);
    assign is_lower   = (ch >= 8'h61) && (ch <= 8'h7A);
    assign is_digit   = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_host_ch = is_upper || is_lower || is_digit ||
                        (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_DOT);
    assign is_end     = (ch == CH_NUL) || (ch == CH_SLASH);

    always_comb
    begin
        act = ACT_IGNORE;
        unique case (eff_phase)
            PH_SLASH1, PH_SLASH2:
            begin
                act = (ch == CH_SLASH) ? ACT_SLASH : ACT_ERROR;
            end
            PH_HOST:
            begin
                priority if (eff_hc >= cfg.hcap)              act = ACT_ERROR;
                else if (is_host_ch && (hc_inc >= cfg.hcap)) act = ACT_ERROR;
                else if (is_host_ch)                         act = ACT_HOST;
                else if (is_end)                             act = ACT_DONE;
                else if (ch == CH_COLON && !cfg.url_mode)    act = ACT_COLON;
                else                                         act = ACT_ERROR;
            end
            PH_PORT:
            begin
                priority if (eff_pc >= cfg.pcap)            act = ACT_ERROR;
                else if (is_digit && (pc_inc >= cfg.pcap)) act = ACT_ERROR;
                else if (is_digit)                         act = ACT_PORT;
                else if (is_end)                           act = ACT_DONE;
                else                                       act = ACT_ERROR;
            end
            default: act = ACT_IGNORE;
        endcase
    end

    always_comb
    begin
        phase_next      = eff_phase;
        host_count_next = eff_hc;
        port_count_next = eff_pc;
        byte_count_next = eff_bc;
        unique case (act)
            ACT_SLASH:
            begin
                byte_count_next = bc_inc;
                phase_next = (eff_phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
            end
            ACT_HOST:
            begin
                host_count_next = hc_inc;
                byte_count_next = bc_inc;
            end
            ACT_COLON:
            begin
                byte_count_next = bc_inc;
                phase_next = PH_PORT;
            end
            ACT_PORT:
            begin
                port_count_next = pc_inc;
                byte_count_next = bc_inc;
            end
            ACT_DONE, ACT_ERROR, ACT_IGNORE:
            begin
                phase_next = PH_ENDED;
            end
            default: phase_next = PH_ENDED;
        endcase
    end

    always_comb
    begin
        res.out_char       = '0;
        res.out_kind       = KIND_NONE;
        res.status         = ST_BUSY;
        res.consumed       = byte_count_next;
        res.port_defaulted = 1'b0;
        unique case (act)
            ACT_SLASH, ACT_COLON: ;
            ACT_HOST:
            begin
                res.out_char = is_upper ? (ch + CH_CASE) : ch;
                res.out_kind = KIND_HOST;
            end
            ACT_PORT:
            begin
                res.out_char = ch;
                res.out_kind = KIND_PORT;
            end
            ACT_DONE:
            begin
                res.status = ST_DONE;
                res.port_defaulted = (eff_phase == PH_HOST) && !cfg.url_mode;
            end
            ACT_ERROR:
            begin
                res.status   = ST_ERROR;
                res.consumed = '0;
            end
            default:
            begin
                res.status   = ST_IGNORED;
                res.consumed = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ENDED;
            host_count_reg <= '0;
            port_count_reg <= '0;
            byte_count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            host_count_reg <= host_count_next;
            port_count_reg <= port_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        fire && start_req |-> res.status != ST_IGNORED)
        else $error("start word reported as ignored");

    a_error_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.status == ST_ERROR |=> phase_reg == PH_ENDED)
        else $error("parse did not end after an error");

    a_char_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.out_kind != KIND_NONE |-> res.status == ST_BUSY)
        else $error("character emitted outside an active parse");

    a_host_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        host_count_reg < HCAP_W'(HOST_MAX))
        else $error("host count reached the host buffer limit");
`endif

endmodule

FILE: design/url_host_port_extractor_unit.sv
// Top level of the URL host and port extractor.
// Input register, parse core and result register; uses url_hpe_pkg,
// url_hpe_cfg and url_hpe_core.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: ch; tuser: start_req
//   m_*      out  m_tvalid/m_tready  tdata: out_char, status, consumed,
//                                    port_defaulted; tuser: out_kind
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Each word gives exactly one result, registered in the result register.
// One word per cycle is sustained while the output is not stalled; the phase
// and counter registers feed back through the parse core.
// Reset leaves the parser ended, so words before a start word are ignored.
// A stalled output holds its result while the input register takes one more word.
module url_host_port_extractor_unit
    import url_hpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] ch
    input  logic             s_tuser,   // [0] start_req
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_char, [9:8] status,
                                        // [18:10] consumed, [19] port_defaulted
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_ch_reg;
    logic              in_start_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              advance;
    cfg_t              cfg;
    res_t              res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    url_hpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    url_hpe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (advance),
        .ch        (in_ch_reg),
        .start_req (in_start_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg    <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_res_reg.port_defaulted, out_res_reg.consumed,
                       out_res_reg.status, out_res_reg.out_char};
    assign m_tuser  = out_res_reg.out_kind;

endmodule

FILE: tb/sv/url_hpe_checker.sv
// Checker for the URL host and port extractor: predicts one result word per input word
// and compares every result word field by field, in order.
// Depends on url_hpe_pkg; watches the stream and register ports of the block.
module url_hpe_checker
    import url_hpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [23:0]      m_tdata,
    input  logic [1:0]       m_tuser,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               err_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic              url_mode;
    logic [HCAP_W-1:0] host_cap;
    logic [PCAP_W-1:0] port_cap;
    phase_t            parse_phase;
    int                host_len;
    int                port_len;
    int                byte_len;
    res_t              parse_results_q[$];

    function automatic logic is_host_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
            || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    function automatic res_t parse_byte(input logic [7:0] c, input logic start);
        res_t r;
        int   hlim;
        int   plim;
        logic bad;
        hlim = (int'(host_cap) > HOST_MAX) ? HOST_MAX : int'(host_cap);
        plim = (int'(port_cap) > PORT_MAX) ? PORT_MAX : int'(port_cap);
        r.out_char = '0;
        r.out_kind = KIND_NONE;
        r.status = ST_BUSY;
        r.consumed = '0;
        r.port_defaulted = 1'b0;
        bad = 1'b0;
        if (start)
        begin
            parse_phase = PH_SLASH1;
            host_len = 0;
            port_len = 0;
            byte_len = 0;
        end
        case (parse_phase)
            PH_SLASH1, PH_SLASH2:
            begin
                if (c != CH_SLASH)
                    bad = 1'b1;
                else
                begin
                    byte_len++;
                    parse_phase = (parse_phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
                end
            end
            PH_HOST:
            begin
                if (host_len >= hlim)
                    bad = 1'b1;
                else if (is_host_byte(c))
                begin
                    if (host_len + 1 >= hlim)
                        bad = 1'b1;
                    else
                    begin
                        host_len++;
                        byte_len++;
                        r.out_kind = KIND_HOST;
                        r.out_char = (c >= "A" && c <= "Z") ? (c | CH_CASE) : c;
                    end
                end
                else if (c == CH_NUL || c == CH_SLASH)
                begin
                    parse_phase = PH_ENDED;
                    r.status = ST_DONE;
                    r.port_defaulted = !url_mode;
                end
                else if (c == CH_COLON && !url_mode)
                begin
                    byte_len++;
                    parse_phase = PH_PORT;
                end
                else
                    bad = 1'b1;
            end
            PH_PORT:
            begin
                if (port_len >= plim)
                    bad = 1'b1;
                else if (c >= "0" && c <= "9")
                begin
                    if (port_len + 1 >= plim)
                        bad = 1'b1;
                    else
                    begin
                        port_len++;
                        byte_len++;
                        r.out_kind = KIND_PORT;
                        r.out_char = c;
                    end
                end
                else if (c == CH_NUL || c == CH_SLASH)
                begin
                    parse_phase = PH_ENDED;
                    r.status = ST_DONE;
                end
                else
                    bad = 1'b1;
            end
            default:
            begin
                parse_phase = PH_ENDED;
                r.status = ST_IGNORED;
            end
        endcase
        if (bad)
        begin
            parse_phase = PH_ENDED;
            r.status = ST_ERROR;
            r.out_kind = KIND_NONE;
            r.out_char = '0;
        end
        else if (r.status != ST_IGNORED)
            r.consumed = BYTE_W'(byte_len);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            url_mode = 1'b0;
            host_cap = HOST_CAP_RESET;
            port_cap = PORT_CAP_RESET;
            parse_phase = PH_ENDED;
            host_len = 0;
            port_len = 0;
            byte_len = 0;
            parse_results_q.delete();
            err_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_URL_MODE: url_mode = cfg_data[0];
                    REG_HOST_CAP: host_cap = cfg_data[HCAP_W-1:0];
                    REG_PORT_CAP: port_cap = cfg_data[PCAP_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (parse_results_q.size() == 0)
                begin
                    $error("result word arrived with no parse result expected");
                    err_count++;
                end
                else
                begin
                    want = parse_results_q.pop_front();
                    check_field("out_char", want.out_char, m_tdata[7:0]);
                    check_field("status", want.status, m_tdata[9:8]);
                    check_field("consumed", want.consumed, m_tdata[18:10]);
                    check_field("port_defaulted", want.port_defaulted, m_tdata[19]);
                    check_field("out_kind", want.out_kind, m_tuser);
                end
            end
            if (s_tvalid && s_tready)
                parse_results_q.push_back(parse_byte(s_tdata, s_tuser));
            pending = parse_results_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the URL host and port extractor testbench: clock, reset, register setup,
// byte stimulus with random idling, and the verdict.
// Depends on url_hpe_pkg, url_hpe_checker and url_host_port_extractor_unit.
module tb_top
    import url_hpe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 200000;
    localparam int NUM_SETTINGS = 8;
    localparam int BYTES_PER_SETTING = 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    int err_count;
    int pending;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int cur_mode = 0;
    int cur_hcap = 64;
    int cur_pcap = 6;

    int set_mode [NUM_SETTINGS] = '{0, 1, 0, 1, 0, 1, 0, 0};
    int set_hcap [NUM_SETTINGS] = '{256, 60, 1, 2, 3, 64, 8, 20};
    int set_pcap [NUM_SETTINGS] = '{16, 15, 1, 2, 16, 1, 2, 9};

    // Bit 8 carries the start flag of the word.
    logic [8:0] directed_words [26] = '{
        {1'b0, 8'h78},
        {1'b1, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h5A}, {1'b0, CH_MINUS},
        {1'b0, CH_DOT}, {1'b0, CH_PLUS}, {1'b0, 8'h39}, {1'b0, CH_COLON},
        {1'b0, 8'h38}, {1'b0, 8'h30}, {1'b0, CH_NUL},
        {1'b0, 8'hFF},
        {1'b1, CH_SLASH}, {1'b0, 8'h78},
        {1'b1, 8'h71},
        {1'b1, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_COLON},
        {1'b1, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_SLASH},
        {1'b1, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_COLON}, {1'b0, CH_SLASH}
    };

    url_host_port_extractor_unit DUT (.*);

    url_hpe_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL url_host_port_extractor_unit");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

    task automatic push_byte(input logic [7:0] c, input logic start);
        logic took;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= start;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(input int mode, input int hcap, input int pcap);
        cfg_we <= 1'b1;
        cfg_index <= REG_URL_MODE;
        cfg_data <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= REG_HOST_CAP;
        cfg_data <= CFG_W'(hcap);
        @(posedge clk);
        cfg_index <= REG_PORT_CAP;
        cfg_data <= CFG_W'(pcap);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
        cur_hcap = hcap;
        cur_pcap = pcap;
    endtask

    // Shape 1 fills the host buffer, shape 2 the port buffer; shape 0 may be broken.
    task automatic send_url(input int shape, output int counted);
        logic [7:0] url_q[$];
        logic [7:0] c;
        int         hlim;
        int         plim;
        int         hl;
        int         pl;
        int         form;
        hlim = (cur_hcap > HOST_MAX) ? HOST_MAX : cur_hcap;
        plim = (cur_pcap > PORT_MAX) ? PORT_MAX : cur_pcap;
        hl = (shape == 1) ? hlim - 1 + $urandom_range(1)
                          : $urandom_range((hlim < 6) ? hlim : 6);
        url_q = '{CH_SLASH, CH_SLASH};
        repeat (hl)
        begin
            case ($urandom_range(4))
                0: c = 8'h61 + 8'($urandom_range(25));
                1: c = 8'h41 + 8'($urandom_range(25));
                2: c = 8'h30 + 8'($urandom_range(9));
                3: c = $urandom_range(1) ? CH_PLUS : CH_MINUS;
                default: c = CH_DOT;
            endcase
            url_q.push_back(c);
        end
        if (shape == 2 || $urandom_range(99) < ((cur_mode == 0) ? 60 : 10))
        begin
            pl = (shape == 2) ? plim - 1 + $urandom_range(1)
                              : $urandom_range((plim < 5) ? plim : 5);
            url_q.push_back(CH_COLON);
            repeat (pl) url_q.push_back(8'h30 + 8'($urandom_range(9)));
        end
        url_q.push_back($urandom_range(1) ? CH_SLASH : CH_NUL);
        counted = url_q.size();
        form = $urandom_range(99);
        if (shape == 0 && form >= 65)
        begin
            if (form < 80)
                url_q[$urandom_range(url_q.size() - 1)] = 8'($urandom_range(255));
            else if (form < 90)
                url_q = url_q[0:$urandom_range(url_q.size() - 1)];
            else
            begin
                url_q.delete();
                repeat ($urandom_range(4, 1)) url_q.push_back(8'($urandom_range(255)));
            end
            counted = url_q.size();
        end
        else
            repeat ($urandom_range(2)) url_q.push_back(8'($urandom_range(255)));
        foreach (url_q[i])
            push_byte(url_q[i], i == 0);
    endtask

    initial
    begin
        int sent;
        int got;
        int n_urls;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_words[i])
            push_byte(directed_words[i][7:0], directed_words[i][8]);
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain();
            set_config(set_mode[s], set_hcap[s], set_pcap[s]);
            case (s % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 59;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 59;
                end
                default:
                begin
                    send_idle = 11;
                    recv_stall = 11;
                end
            endcase
            sent = 0;
            n_urls = 0;
            while (sent < BYTES_PER_SETTING || n_urls < 3)
            begin
                if ($urandom_range(39) == 0)
                    drain();
                send_url((n_urls < 2) ? n_urls + 1 : 0, got);
                sent += got;
                n_urls++;
            end
        end
        drain();
        if (err_count == 0)
            $display("PASS url_host_port_extractor_unit");
        else
            $display("FAIL url_host_port_extractor_unit");
        $finish;
    end

endmodule

FILE: filelist.f
design/url_hpe_pkg.sv
design/url_hpe_cfg.sv
design/url_hpe_core.sv
design/url_host_port_extractor_unit.sv
tb/sv/url_hpe_checker.sv
tb/sv/tb_top.sv
